>>> src/tgw_pkg.sv
// tgw_pkg: types and fixed constants of the text grid glyph writer
// no dependencies; imported by the layout, buffer and top modules

package tgw_pkg;

  // most results one input byte can cause
  localparam int MAX_RESULTS = 4;

  // character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CUSTOM_MAX = 8'h03;
  localparam logic [7:0] LEAD_MIN   = 8'hA1;
  localparam logic [7:0] LEAD_SPLIT = 8'hB0;
  localparam logic [7:0] LEAD_GAP   = 8'h06;

  // glyph code construction
  localparam logic [15:0] ROW_STRIDE = 16'd94;
  localparam logic [15:0] HALF_BASE  = 16'h4000;
  localparam logic [15:0] ASCII_BASE = 16'h2000;
  localparam logic [15:0] CUSTOM_OFS = 16'd34;
  localparam logic [3:0]  ROWS_MAX   = 4'd15;

  // one input item
  typedef struct packed {
    logic       first;
    logic [3:0] start_line;
    logic [4:0] start_col;
    logic [7:0] char_byte;
  } tgw_item_t;

  // one result item
  typedef struct packed {
    logic        is_write;
    logic [3:0]  cell_line;
    logic [4:0]  cell_col;
    logic [15:0] cell_code;
    logic [3:0]  end_line;
    logic [4:0]  end_col;
    logic [3:0]  rows_used;
    logic        last;
  } tgw_result_t;

  // all results of one input byte
  typedef struct packed {
    tgw_result_t [MAX_RESULTS-1:0] res;
    logic [2:0]                    cnt;
  } tgw_batch_t;

endpackage

>>> src/tgw_if.sv
// tgw_if: valid/ready channel interfaces for input bytes, results and config
// no dependencies

interface tgw_in_if;
  logic       valid;
  logic       ready;
  logic       first;
  logic [3:0] start_line;
  logic [4:0] start_col;
  logic [7:0] char_byte;

  modport source (output valid, first, start_line, start_col, char_byte, input ready);
  modport sink (input valid, first, start_line, start_col, char_byte, output ready);
endinterface

interface tgw_out_if;
  logic        valid;
  logic        ready;
  logic        is_write;
  logic [3:0]  cell_line;
  logic [4:0]  cell_col;
  logic [15:0] cell_code;
  logic [3:0]  end_line;
  logic [4:0]  end_col;
  logic [3:0]  rows_used;
  logic        last;

  modport source (output valid, is_write, cell_line, cell_col, cell_code, end_line,
                  end_col, rows_used, last, input ready);
  modport sink (input valid, is_write, cell_line, cell_col, cell_code, end_line,
                end_col, rows_used, last, output ready);
endinterface

interface tgw_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] indent_col;

  modport source (output valid, indent_col, input ready);
  modport sink (input valid, indent_col, output ready);
endinterface

>>> src/tgw_layout.sv
// tgw_layout: cursor state and the single-pass layout of one byte into results
// depends on tgw_pkg

module tgw_layout import tgw_pkg::*; #(
  parameter int GRID_LINES = 10,
  parameter int GRID_COLS  = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  tgw_item_t  item,
  input  logic [4:0] indent_col,
  output tgw_batch_t batch
);

  localparam logic [4:0] LINES_W  = 5'(GRID_LINES);
  localparam logic [5:0] COLS_W   = 6'(GRID_COLS);
  localparam logic [4:0] COL_LAST = 5'(GRID_COLS - 1);

  logic [3:0] cur_line_r, cur_line_nxt;
  logic [4:0] cur_col_r, cur_col_nxt;
  logic [3:0] row_count_r, row_count_nxt;
  logic       running_r, running_nxt;
  logic       lead_pending_r, lead_pending_nxt;
  logic [7:0] lead_byte_r, lead_byte_nxt;

  // working values of the single pass
  logic [4:0]  line;
  logic [5:0]  col;
  logic [4:0]  ind;
  logic        done;
  logic [2:0]  n;
  logic [7:0]  b;
  logic [7:0]  x;
  logic [15:0] code;
  tgw_result_t [MAX_RESULTS-1:0] res;

  function automatic tgw_result_t write_res(logic [4:0] l, logic [5:0] c, logic [15:0] g);
    tgw_result_t r;
    r = '0;
    r.is_write  = 1'b1;
    r.cell_line = l[3:0];
    r.cell_col  = c[4:0];
    r.cell_code = g;
    return r;
  endfunction

  function automatic tgw_result_t end_res(logic [4:0] l, logic [5:0] c, logic [3:0] rows);
    tgw_result_t r;
    r = '0;
    r.end_line  = l[3:0];
    r.end_col   = c[4:0];
    r.rows_used = rows;
    return r;
  endfunction

  // effective wrap column
  assign ind = (indent_col >= COLS_W[4:0] && COLS_W < 6'd32) ? COL_LAST : indent_col;

  // layout of one byte: up to four results and the next cursor state
  always_comb begin
    line             = {1'b0, cur_line_r};
    col              = {1'b0, cur_col_r};
    row_count_nxt    = row_count_r;
    running_nxt      = running_r;
    lead_pending_nxt = lead_pending_r;
    lead_byte_nxt    = lead_byte_r;
    done             = 1'b0;
    n                = 3'd0;
    res              = '0;
    b                = item.char_byte;
    x                = 8'd0;
    code             = 16'd0;

    // start of a new string
    if (item.first) begin
      lead_pending_nxt = 1'b0;
      running_nxt      = 1'b1;
      line             = {1'b0, item.start_line};
      col              = {1'b0, item.start_col};
      if (line >= LINES_W) begin
        row_count_nxt = 4'd0;
        done          = 1'b1;
      end else begin
        row_count_nxt = 4'd1;
        if (col >= COLS_W) begin
          col  = {1'b0, ind};
          line = line + 5'd1;
        end
        if (line >= LINES_W) begin
          done = 1'b1;
        end
      end
      if (done) begin
        res[n[1:0]]      = end_res(line, col, row_count_nxt);
        n                = n + 3'd1;
        running_nxt      = 1'b0;
        lead_pending_nxt = 1'b0;
      end
    end

    if (!done && running_nxt) begin
      if (lead_pending_nxt) begin
        // trail byte of a wide character
        lead_pending_nxt = 1'b0;
        x = lead_byte_r;
        if (x >= LEAD_SPLIT) begin
          x = x - LEAD_GAP;
        end
        code = 16'(x - LEAD_MIN) * ROW_STRIDE + 16'(b) - 16'(LEAD_MIN);
        code = {code[14:0], 1'b0} + HALF_BASE;
        // no room for both halves: blank the last cell and wrap
        if (col + 6'd1 >= COLS_W) begin
          res[n[1:0]] = write_res(line, col, 16'd0);
          n           = n + 3'd1;
          col         = {1'b0, ind};
          line        = line + 5'd1;
          done        = (line >= LINES_W);
        end
        // first half
        if (!done) begin
          res[n[1:0]] = write_res(line, col, code);
          n           = n + 3'd1;
          col         = col + 6'd1;
          if (col >= COLS_W) begin
            col  = {1'b0, ind};
            line = line + 5'd1;
            done = (line >= LINES_W);
          end
        end
        // second half
        if (!done) begin
          res[n[1:0]] = write_res(line, col, code + 16'd1);
          n           = n + 3'd1;
          col         = col + 6'd1;
          if (col >= COLS_W) begin
            col  = {1'b0, ind};
            line = line + 5'd1;
            done = (line >= LINES_W);
          end
        end
      end else if (b == CH_NUL) begin
        done = 1'b1;
      end else if (b == CH_LF) begin
        line = line + 5'd1;
        if (line >= LINES_W) begin
          done = 1'b1;
        end else if (row_count_nxt < ROWS_MAX) begin
          row_count_nxt = row_count_nxt + 4'd1;
        end
      end else if (b == CH_CR) begin
        col = 6'd0;
      end else if (b >= LEAD_MIN) begin
        lead_pending_nxt = 1'b1;
        lead_byte_nxt    = b;
      end else begin
        // narrow glyph
        code        = (b <= CUSTOM_MAX) ? 16'(b) + CUSTOM_OFS : 16'(b) + ASCII_BASE;
        res[n[1:0]] = write_res(line, col, code);
        n           = n + 3'd1;
        col         = col + 6'd1;
        if (col >= COLS_W) begin
          col  = {1'b0, ind};
          line = line + 5'd1;
          done = (line >= LINES_W);
        end
      end
      // end of string report
      if (done) begin
        res[n[1:0]]      = end_res(line, col, row_count_nxt);
        n                = n + 3'd1;
        running_nxt      = 1'b0;
        lead_pending_nxt = 1'b0;
      end
    end

    // mark the final result of this byte
    if (n != 3'd0) begin
      res[2'(n - 3'd1)].last = 1'b1;
    end

    cur_line_nxt = line[3:0];
    cur_col_nxt  = col[4:0];
    batch.res    = res;
    batch.cnt    = n;
  end

  // cursor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_line_r     <= '0;
      cur_col_r      <= '0;
      row_count_r    <= '0;
      running_r      <= 1'b0;
      lead_pending_r <= 1'b0;
      lead_byte_r    <= '0;
    end else if (take) begin
      cur_line_r     <= cur_line_nxt;
      cur_col_r      <= cur_col_nxt;
      row_count_r    <= row_count_nxt;
      running_r      <= running_nxt;
      lead_pending_r <= lead_pending_nxt;
      lead_byte_r    <= lead_byte_nxt;
    end
  end

endmodule

>>> src/tgw_result_buf.sv
// tgw_result_buf: holds a byte's results, hands one out per cycle while ready
// depends on tgw_pkg and tgw_out_if

module tgw_result_buf import tgw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  tgw_batch_t batch,
  output logic       can_load,
  tgw_out_if.source  out_ch
);

  tgw_result_t [MAX_RESULTS-1:0] res_r;
  logic [2:0] rem_r;
  logic [1:0] idx_r;
  logic       fire;
  tgw_result_t cur;

  assign fire     = out_ch.valid && out_ch.ready;
  assign can_load = (rem_r == 3'd0) || (rem_r == 3'd1 && out_ch.ready);
  assign cur      = res_r[idx_r];

  // result port
  assign out_ch.valid     = (rem_r != 3'd0);
  assign out_ch.is_write  = cur.is_write;
  assign out_ch.cell_line = cur.cell_line;
  assign out_ch.cell_col  = cur.cell_col;
  assign out_ch.cell_code = cur.cell_code;
  assign out_ch.end_line  = cur.end_line;
  assign out_ch.end_col   = cur.end_col;
  assign out_ch.rows_used = cur.rows_used;
  assign out_ch.last      = cur.last;

  // result storage
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= batch.res;
    end
  end

  // read pointer and remaining count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      rem_r <= batch.cnt;
      idx_r <= '0;
    end else if (fire) begin
      rem_r <= rem_r - 3'd1;
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule

>>> src/text_grid_glyph_writer.sv
// text_grid_glyph_writer: top level, input register, indent register and wiring
// depends on tgw_pkg, tgw_if, tgw_layout and tgw_result_buf

// Lays out a byte string on a GRID_LINES x GRID_COLS character grid and emits
// cell writes with glyph codes, plus an end report when the string stops.
// A byte is taken into an input register, laid out combinationally, and its
// zero to four results land in a four-entry result buffer that drives the
// result port one item per cycle while the port is ready; the first result
// is offered once the byte has passed the input register and been loaded
// into the buffer. Bytes that cause at most one result flow at one per cycle
// while the port is ready; a byte with several results holds the port until
// all are taken, so the sustained rate is set by the single result port. The
// next byte is laid out in the cycle its predecessor's final result is taken.
// indent_col is written through the always-ready config channel; the user
// must write it only while the block is idle; the block leaves this to them.

module text_grid_glyph_writer import tgw_pkg::*; #(
  parameter int GRID_LINES = 10,
  parameter int GRID_COLS  = 20
) (
  input  logic      clk,
  input  logic      rst_n,
  tgw_in_if.sink    in_ch,
  tgw_out_if.source out_ch,
  tgw_cfg_if.sink   cfg_ch
);

  logic       cfg_fire;
  logic [4:0] indent_col_r;
  logic       in_vld_r;
  tgw_item_t  item_r;
  logic       can_load;
  logic       take;
  tgw_batch_t batch;

  assign take         = in_vld_r && can_load;
  assign in_ch.ready  = !in_vld_r || can_load;
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  // indent register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      indent_col_r <= '0;
    end else if (cfg_fire) begin
      indent_col_r <= cfg_ch.indent_col;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.first      <= in_ch.first;
      item_r.start_line <= in_ch.start_line;
      item_r.start_col  <= in_ch.start_col;
      item_r.char_byte  <= in_ch.char_byte;
    end
  end

  tgw_layout #(
    .GRID_LINES (GRID_LINES),
    .GRID_COLS  (GRID_COLS)
  ) u_layout (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .item       (item_r),
    .indent_col (indent_col_r),
    .batch      (batch)
  );

  tgw_result_buf u_result_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take),
    .batch    (batch),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule
